// ===== hdl/nru_pkg.sv =====
package nru_pkg;

   localparam int DIVISOR_W     = 31;
   localparam int REM_W         = 32;
   localparam int FRACTION_BITS = 64;
   localparam int SHIFT_W       = 6;
   localparam int STEP_LIMIT    = 128;
   localparam int STEP_W        = $clog2(STEP_LIMIT + 1);

   localparam int REQ_TDATA_W = ((DIVISOR_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((FRACTION_BITS + SHIFT_W + 7) / 8) * 8;

   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } nru_cmd_type;

   typedef struct packed {
      logic done;
   } nru_status_type;

endpackage

// ===== hdl/nru_datapath.sv =====
module nru_datapath
   import nru_pkg::*;
(
   input  logic                       clock,
   input  nru_cmd_type                cmd,
   output nru_status_type             status,
   input  logic [DIVISOR_W-1:0]       divisor,
   output logic [FRACTION_BITS-1:0]   reciprocal_fraction,
   output logic [SHIFT_W-1:0]         shift_count
);

   logic [DIVISOR_W-1:0]     divisor_ff, divisor_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [FRACTION_BITS-1:0] frac_ff, frac_in;
   logic [STEP_W-1:0]        steps_ff, steps_in;
   logic [FRACTION_BITS-1:0] rsp_frac_ff, rsp_frac_in;
   logic [SHIFT_W-1:0]       rsp_shift_ff, rsp_shift_in;

   logic [REM_W-1:0]         rem_sh;
   logic                     fits;
   logic [FRACTION_BITS-1:0] rnd_frac;
   logic [STEP_W-1:0]        rnd_steps;
   logic [STEP_W-1:0]        shift_full;

   assign rem_sh = {rem_ff[REM_W-2:0], 1'b0};
   assign fits   = rem_sh >= {{(REM_W-DIVISOR_W){1'b0}}, divisor_ff};

   assign status.done = frac_ff[FRACTION_BITS-1] ||
                        (steps_ff == STEP_W'(STEP_LIMIT));

   // round up an inexact quotient; an all-ones fraction wraps to the top bit
   always_comb begin
      rnd_frac  = frac_ff;
      rnd_steps = steps_ff;
      if (rem_ff != '0) begin
         if (&frac_ff) begin
            rnd_frac  = {1'b1, {(FRACTION_BITS-1){1'b0}}};
            rnd_steps = steps_ff - STEP_W'(1);
         end else begin
            rnd_frac  = frac_ff + FRACTION_BITS'(1);
         end
      end
   end

   assign shift_full = rnd_steps - STEP_W'(FRACTION_BITS);

   always_comb begin
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      frac_in      = frac_ff;
      steps_in     = steps_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_shift_in = rsp_shift_ff;
      if (cmd.load) begin
         divisor_in = divisor;
         rem_in     = REM_W'(1);
         frac_in    = '0;
         steps_in   = '0;
      end else if (cmd.step) begin
         steps_in = steps_ff + STEP_W'(1);
         if (fits) begin
            rem_in  = rem_sh - {{(REM_W-DIVISOR_W){1'b0}}, divisor_ff};
            frac_in = {frac_ff[FRACTION_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            frac_in = {frac_ff[FRACTION_BITS-2:0], 1'b0};
         end
      end
      if (cmd.publish) begin
         rsp_frac_in  = rnd_frac;
         rsp_shift_in = shift_full[SHIFT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      frac_ff      <= frac_in;
      steps_ff     <= steps_in;
      rsp_frac_ff  <= rsp_frac_in;
      rsp_shift_ff <= rsp_shift_in;
   end

   assign reciprocal_fraction = rsp_frac_ff;
   assign shift_count         = rsp_shift_ff;

endmodule

// ===== hdl/nru_ctrl.sv =====
module nru_ctrl
   import nru_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output nru_cmd_type    cmd,
   input  nru_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_ROUND
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign req_tready  = (state_ff == ST_IDLE);
   assign out_free    = !out_valid_ff || rsp_tready;
   assign cmd.load    = req_tvalid && req_tready;
   assign cmd.step    = (state_ff == ST_RUN) && !status.done;
   assign cmd.publish = (state_ff == ST_ROUND) && out_free;
   assign rsp_tvalid  = out_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.done) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            // hold the rounded word until the output register frees up
            if (cmd.publish) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.publish) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_starts_run: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_RUN))
      else $error("accepted word did not start division");

   a_done_rounds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RUN) && status.done) |=> (state_ff == ST_ROUND))
      else $error("finished division did not move to rounding");

   a_publish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> out_valid_ff)
      else $error("published word not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(cmd.publish && out_valid_ff && !rsp_tready))
      else $error("pending result overwritten");

   a_step_only_running: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (state_ff == ST_RUN) && !cmd.load)
      else $error("step issued outside division");
`endif

endmodule

// ===== hdl/normalized_reciprocal_unit.sv =====
// Normalized reciprocal unit.
// Input channel req_*: one word per divisor; a word is taken when req_tvalid
// and req_tready are both high. req_tready is high only while no division
// is under way, so the block works on one divisor at a time.
// Result channel rsp_*: one word per divisor, the 64-bit fraction with its
// top bit set (rounded up if inexact) and a 6-bit signed shift, the number
// of quotient bits minus 64.
// Sequence: the restoring step loop produces one quotient bit a cycle (64
// to 94 bits, set by the divisor's magnitude); the controller then sees the
// top fraction bit set and moves to rounding, which writes the rounded word
// into the output register once that register is free. A new divisor can
// be taken the cycle after the result is registered, so the block finishes
// one divisor before it takes the next.
// Stall: the finished result waits in the output register while the next
// divisor is accepted and divided; a second result holds in the rounding
// step until the first is taken.
// Reset: synchronous, active high; clears the controller and drops
// rsp_tvalid. No memory needs clearing.
module normalized_reciprocal_unit
   import nru_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [30:0] divisor
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [63:0] reciprocal_fraction, [69:64] shift_count
);

   nru_cmd_type              cmd;
   nru_status_type           status;
   logic [FRACTION_BITS-1:0] reciprocal_fraction;
   logic [SHIFT_W-1:0]       shift_count;

   nru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   nru_datapath u_datapath (
      .clock               (clock),
      .cmd                 (cmd),
      .status              (status),
      .divisor             (req_tdata[DIVISOR_W-1:0]),
      .reciprocal_fraction (reciprocal_fraction),
      .shift_count         (shift_count)
   );

   assign rsp_tdata = {{(RSP_TDATA_W-FRACTION_BITS-SHIFT_W){1'b0}},
                       shift_count, reciprocal_fraction};

endmodule

// ===== tb/tb_normalized_reciprocal_unit.sv =====
module tb_normalized_reciprocal_unit;
   import nru_pkg::*;

   typedef struct {
      logic [FRACTION_BITS-1:0] fraction;
      logic [SHIFT_W-1:0]       shift;
   } reciprocal_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [30:0] divisor
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [63:0] reciprocal_fraction, [69:64] shift_count

   reciprocal_type pending_reciprocals[$];
   int             divisors_sent = 0;
   int             results_checked = 0;
   int             error_count = 0;
   bit             sender_idling = 1'b1;
   bit             receiver_idling = 1'b1;
   int             stall_left = 0;

   normalized_reciprocal_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Restoring division of 1 by the divisor until the top fraction bit is set,
   // then round up if anything is left over.
   function automatic reciprocal_type reciprocal_of(input logic [DIVISOR_W-1:0] divisor);
      logic [REM_W-1:0]         dv;
      logic [REM_W-1:0]         rem;
      logic [FRACTION_BITS-1:0] frac;
      int                       bits;
      reciprocal_type           res;
      dv   = REM_W'(divisor);
      rem  = REM_W'(1);
      frac = '0;
      bits = 0;
      for (int i = 0; i < STEP_LIMIT && !frac[FRACTION_BITS-1]; i++) begin
         bits = bits + 1;
         frac = frac << 1;
         rem  = rem << 1;
         if (rem >= dv) begin
            rem     = rem - dv;
            frac[0] = 1'b1;
         end
      end
      if (rem != 0) begin
         // all-ones fraction: rounding would carry out, so renormalize
         if (&frac) begin
            frac                   = '0;
            frac[FRACTION_BITS-1]  = 1'b1;
            bits                   = bits - 1;
         end else begin
            frac = frac + FRACTION_BITS'(1);
         end
      end
      res.fraction = frac;
      res.shift    = SHIFT_W'(bits - FRACTION_BITS);
      return res;
   endfunction

   // Entered and left at a falling edge; req_tvalid stays high on return so
   // that back-to-back words need no second assignment in one step.
   task automatic send_divisor(input logic [DIVISOR_W-1:0] divisor);
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(divisor);
      do @(posedge clock); while (!req_tready);
      pending_reciprocals.push_back(reciprocal_of(divisor));
      divisors_sent++;
      @(negedge clock);
   endtask

   function automatic logic [DIVISOR_W-1:0] divisor_of_width(input int w);
      logic [DIVISOR_W-1:0] top_bit;
      top_bit = DIVISOR_W'(1) << (w - 1);
      return top_bit | (DIVISOR_W'($urandom) & (top_bit - DIVISOR_W'(1)));
   endfunction

   task automatic test_directed_edges();
      logic [DIVISOR_W-1:0] edge_divisors[$];
      edge_divisors = '{31'd1, 31'd0, 31'd2, 31'd3, 31'd5, 31'd7, 31'd10,
                        31'h7fffffff, 31'h7ffffffe, 31'h40000000, 31'h40000001,
                        31'h3fffffff, 31'h55555555, 31'h2aaaaaaa, 31'h00008000,
                        31'h00008001, 31'h00007fff, 31'd1000003, 31'h12345678,
                        31'h6db6db6d};
      foreach (edge_divisors[i]) send_divisor(edge_divisors[i]);
   endtask

   task automatic test_power_neighbors(input int count);
      int                   k;
      logic [DIVISOR_W-1:0] base;
      for (int i = 0; i < count; i++) begin
         k    = $urandom_range(0, DIVISOR_W - 1);
         base = DIVISOR_W'(1) << k;
         case ($urandom_range(0, 2))
            0:       send_divisor(base - DIVISOR_W'(1));
            1:       send_divisor(base);
            default: send_divisor(base + DIVISOR_W'(1));
         endcase
      end
   endtask

   // Spread magnitudes evenly so that short and long divisions both appear.
   task automatic test_random_magnitudes(input int count);
      for (int i = 0; i < count; i++)
         send_divisor(divisor_of_width($urandom_range(1, DIVISOR_W)));
   endtask

   task automatic test_random_full_range(input int count);
      for (int i = 0; i < count; i++) send_divisor(DIVISOR_W'($urandom));
   endtask

   task automatic test_streaming(input int count);
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 1) == 0) send_divisor(DIVISOR_W'($urandom));
         else send_divisor(divisor_of_width($urandom_range(1, DIVISOR_W)));
      end
   endtask

   // Result side back-pressure in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(1, 13) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      reciprocal_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reciprocals.size() == 0) begin
            $display("%0t: unexpected word, got fraction %h shift %0d", $time,
                     rsp_tdata[FRACTION_BITS-1:0],
                     $signed(rsp_tdata[FRACTION_BITS +: SHIFT_W]));
            error_count++;
         end else begin
            want = pending_reciprocals.pop_front();
            results_checked++;
            if (rsp_tdata[FRACTION_BITS-1:0] !== want.fraction) begin
               $display("%0t: fraction expected %h actual %h", $time, want.fraction,
                        rsp_tdata[FRACTION_BITS-1:0]);
               error_count++;
            end
            if (rsp_tdata[FRACTION_BITS +: SHIFT_W] !== want.shift) begin
               $display("%0t: shift expected %0d actual %0d", $time, $signed(want.shift),
                        $signed(rsp_tdata[FRACTION_BITS +: SHIFT_W]));
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_edges();
      test_power_neighbors(150);
      test_random_magnitudes(880);
      test_random_full_range(500);
      test_streaming(200);
      req_tvalid <= 1'b0;
      while (pending_reciprocals.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      $display("Sent %0d divisors (edges, power-of-two neighbors, all magnitudes, full range,",
               divisors_sent);
      $display("stall-free streaming); %0d reciprocals checked.", results_checked);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding", pending_reciprocals.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
